/* src/clit_pkg.sv */
package clit_pkg;

    localparam int RANGE_W = 16;
    localparam int ANGLE_W = 14;
    localparam int RPM_W   = 15;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 5;
    localparam int IDX_W   = 4;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int PROD_W  = RANGE_W + RPM_W;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [STAT_W-1:0] ST_INTERP = 2'd0;
    localparam logic [STAT_W-1:0] ST_CLAMP  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOMAP  = 2'd2;

    // register index taken from paddr[2]
    localparam logic REG_POINT_COUNT = 1'b0;

    localparam logic [CNT_W-1:0] COUNT_RESET = 5'd4;
    localparam int STARTER_N = 4;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic [ANGLE_W-1:0] angle;
        logic [RPM_W-1:0]   rpm;
    } t_point;

    // query walking down the cell row
    typedef struct packed {
        logic               vld;
        logic               done;
        logic               found;
        logic [STAT_W-1:0]  status;
        logic [RANGE_W-1:0] r;
        t_point             prev;
        t_point             lo;
        t_point             hi;
    } t_token;

    function automatic t_point starter_point(input int k);
        t_point p;
        p = '0;
        case (k)
            0: p = '{range_mm: 16'd1500, angle: 14'd2000, rpm: 15'd2500};
            1: p = '{range_mm: 16'd2500, angle: 14'd2800, rpm: 15'd3200};
            2: p = '{range_mm: 16'd3500, angle: 14'd3400, rpm: 15'd3900};
            3: p = '{range_mm: 16'd4500, angle: 14'd3900, rpm: 15'd4500};
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

/* src/clit_if.sv */
interface clit_req_if;
    import clit_pkg::*;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [RANGE_W-1:0] range_mm;
    logic [IDX_W-1:0]   entry_index;
    logic [ANGLE_W-1:0] entry_angle;
    logic [RPM_W-1:0]   entry_rpm;
    modport source (output valid, operation, range_mm, entry_index, entry_angle, entry_rpm,
                    input ready);
    modport sink   (input valid, operation, range_mm, entry_index, entry_angle, entry_rpm,
                    output ready);
endinterface

interface clit_rsp_if;
    import clit_pkg::*;
    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] echo_range_mm;
    logic [ANGLE_W-1:0] hood_angle;
    logic [RPM_W-1:0]   flywheel_rpm;
    logic [STAT_W-1:0]  status;
    modport source (output valid, echo_range_mm, hood_angle, flywheel_rpm, status,
                    input ready);
    modport sink   (input valid, echo_range_mm, hood_angle, flywheel_rpm, status,
                    output ready);
endinterface

/* src/clit_cell.sv */
module clit_cell #(
    parameter int K  = 0,
    parameter int NW = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [clit_pkg::IDX_W-1:0]    i_wr_idx,
    input  clit_pkg::t_point              i_wr_pt,
    input  logic [NW-1:0]                 i_n,
    input  clit_pkg::t_token              i_tok,
    output clit_pkg::t_token              o_tok
);
    import clit_pkg::*;

    localparam logic [NW-1:0] KN  = NW'(K);
    localparam logic [NW-1:0] KN1 = NW'(K + 1);

    t_point r_pt;
    t_token r_tok;
    t_token n_tok;
    logic   wr_hit;

    assign wr_hit = i_wr && (K < (1 << IDX_W)) && (i_wr_idx == IDX_W'(K));

    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld && !i_tok.done) begin
            if (K == 0) begin
                if (i_n == '0) begin
                    n_tok.done   = 1'b1;
                    n_tok.status = ST_NOMAP;
                    n_tok.lo     = '0;
                end else if (i_n == KN1 || i_tok.r <= r_pt.range_mm) begin
                    n_tok.done   = 1'b1;
                    n_tok.status = ST_CLAMP;
                    n_tok.lo     = r_pt;
                end
            end else if (i_n > KN) begin
                // first bracketing pair wins
                if (!i_tok.found && i_tok.r >= i_tok.prev.range_mm
                        && i_tok.r <= r_pt.range_mm) begin
                    n_tok.found = 1'b1;
                    n_tok.lo    = i_tok.prev;
                    n_tok.hi    = r_pt;
                end
                if (i_n == KN1) begin
                    n_tok.done = 1'b1;
                    if (i_tok.r >= r_pt.range_mm) begin
                        n_tok.status = ST_CLAMP;
                        n_tok.lo     = r_pt;
                    end else if (n_tok.found) begin
                        n_tok.status = ST_INTERP;
                    end else begin
                        n_tok.status = ST_NOMAP;
                        n_tok.lo     = '0;
                    end
                end
            end
            n_tok.prev = r_pt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            if (K < STARTER_N) begin
                r_pt <= starter_point(K);
            end
        end else if (wr_hit) begin
            r_pt <= i_wr_pt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

/* src/clit_div.sv */
module clit_div #(
    parameter int DW = 31,
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);
    localparam int CW = $clog2(DW + 1);

    logic [VW:0]   r_rem;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [VW:0]   rem_sh;
    logic          take;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {r_rem[VW-1:0], r_quo[DW-1]};
    assign take   = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= take ? (rem_sh - {1'b0, r_div}) : rem_sh;
                r_quo <= {r_quo[DW-2:0], take};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

/* src/clamped_linear_interpolation_table_unit.sv */
// Piecewise-linear calibration lookup. Up to MAX_POINTS points (range mm, hood angle in
// 0.01 deg, flywheel rpm) live one per cell in a row of cells; entries must be loaded
// in ascending range order, and point_count (APB, offset 0) says how many are in use,
// from slot 0. A write item (operation 1) loads one slot in its transfer cycle and
// gives no result. A query (operation 0) walks the row one cell per cycle, then for an
// interpolated answer passes through a multiply state, a start state and a
// shift-subtract divide. One query is in flight at a time: no new item is accepted
// until its result has been loaded into the output register.
// Queries at or beyond either end return that end point with status clamped, an empty
// table returns status no map with zero values, and interpolation truncates toward zero.
// After reset slots 0..3 hold the starter points; other slots are unknown until written.
module clamped_linear_interpolation_table_unit #(
    parameter int MAX_POINTS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    clit_req_if.sink                       i_req,
    clit_rsp_if.source                     o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [clit_pkg::PADDR_W-1:0]   paddr,
    input  logic [clit_pkg::PDATA_W-1:0]   pwdata,
    output logic [clit_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import clit_pkg::*;

    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int CW = (NW > CNT_W) ? NW : CNT_W;

    typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_MUL, S_START, S_DIV, S_OUT} t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [NW-1:0]      n_pts;
    logic [CW-1:0]      cnt_x;
    logic               req_xfer;
    logic               cfg_wr;

    // working registers of one query
    logic [RANGE_W-1:0] r_q;
    logic [STAT_W-1:0]  r_st;
    logic [ANGLE_W-1:0] r_ang;
    logic [RPM_W-1:0]   r_rpm;
    t_point             r_lo;
    logic [RANGE_W-1:0] r_off;
    logic [RANGE_W-1:0] r_span;
    logic [ANGLE_W-1:0] r_dang;
    logic [RPM_W-1:0]   r_drpm;
    logic               r_neg_a;
    logic               r_neg_r;
    logic [PROD_W-1:0]  r_prod_a;
    logic [PROD_W-1:0]  r_prod_r;

    // output register
    logic               r_ovld;
    logic [RANGE_W-1:0] r_orange;
    logic [ANGLE_W-1:0] r_oang;
    logic [RPM_W-1:0]   r_orpm;
    logic [STAT_W-1:0]  r_ost;

    t_token             tok [MAX_POINTS+1];
    t_token             tail;
    t_point             wr_pt;
    logic               div_start;
    logic               done_a;
    logic               done_r;
    logic [PROD_W-1:0]  quot_a;
    logic [PROD_W-1:0]  quot_r;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_POINT_COUNT);
    assign prdata = (paddr[2] == REG_POINT_COUNT) ? PDATA_W'(r_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (cfg_wr) begin
            r_count <= pwdata[CNT_W-1:0];
        end
    end

    // count above capacity acts as full table
    assign cnt_x = CW'(r_count);
    assign n_pts = (cnt_x > CW'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(cnt_x);

    // ---------------- cell row ----------------
    assign i_req.ready = (r_state == S_IDLE);
    assign req_xfer    = i_req.valid && i_req.ready;
    assign wr_pt       = '{range_mm: i_req.range_mm, angle: i_req.entry_angle,
                           rpm: i_req.entry_rpm};

    always_comb begin
        tok[0]       = '0;
        tok[0].vld   = req_xfer && (i_req.operation == OP_QUERY);
        tok[0].r     = i_req.range_mm;
    end

    for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
        clit_cell #(.K(k), .NW(NW)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr     (req_xfer && (i_req.operation == OP_WRITE)),
            .i_wr_idx (i_req.entry_index),
            .i_wr_pt  (wr_pt),
            .i_n      (n_pts),
            .i_tok    (tok[k]),
            .o_tok    (tok[k+1])
        );
    end

    assign tail = tok[MAX_POINTS];

    // ---------------- interpolation dividers ----------------
    assign div_start = (r_state == S_START);

    clit_div #(.DW(PROD_W), .VW(RANGE_W)) u_div_ang (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod_a),
        .i_divisor  (r_span),
        .o_done     (done_a),
        .o_quot     (quot_a)
    );

    clit_div #(.DW(PROD_W), .VW(RANGE_W)) u_div_rpm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod_r),
        .i_divisor  (r_span),
        .o_done     (done_r),
        .o_quot     (quot_r)
    );

    // ---------------- sequencer and output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            // S_OUT reloads the output register itself
            if (r_ovld && o_rsp.ready && r_state != S_OUT) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (req_xfer && i_req.operation == OP_QUERY) begin
                        r_q     <= i_req.range_mm;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (tail.vld) begin
                        r_st <= tail.status;
                        r_lo <= tail.lo;
                        if (tail.status != ST_INTERP
                                || tail.hi.range_mm == tail.lo.range_mm) begin
                            // clamp, no map or zero span: lower point as is
                            r_ang   <= tail.lo.angle;
                            r_rpm   <= tail.lo.rpm;
                            r_state <= S_OUT;
                        end else begin
                            r_off   <= tail.r - tail.lo.range_mm;
                            r_span  <= tail.hi.range_mm - tail.lo.range_mm;
                            r_neg_a <= tail.hi.angle < tail.lo.angle;
                            r_neg_r <= tail.hi.rpm < tail.lo.rpm;
                            r_dang  <= (tail.hi.angle < tail.lo.angle)
                                       ? tail.lo.angle - tail.hi.angle
                                       : tail.hi.angle - tail.lo.angle;
                            r_drpm  <= (tail.hi.rpm < tail.lo.rpm)
                                       ? tail.lo.rpm - tail.hi.rpm
                                       : tail.hi.rpm - tail.lo.rpm;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod_a <= PROD_W'(r_off) * PROD_W'(r_dang);
                    r_prod_r <= PROD_W'(r_off) * PROD_W'(r_drpm);
                    r_state  <= S_START;
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (done_a) begin
                        // quotient never exceeds the magnitude of the difference
                        r_ang   <= r_neg_a ? r_lo.angle - quot_a[ANGLE_W-1:0]
                                           : r_lo.angle + quot_a[ANGLE_W-1:0];
                        r_rpm   <= r_neg_r ? r_lo.rpm - quot_r[RPM_W-1:0]
                                           : r_lo.rpm + quot_r[RPM_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovld || o_rsp.ready) begin
                        r_ovld   <= 1'b1;
                        r_orange <= r_q;
                        r_oang   <= r_ang;
                        r_orpm   <= r_rpm;
                        r_ost    <= r_st;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid         = r_ovld;
    assign o_rsp.echo_range_mm = r_orange;
    assign o_rsp.hood_angle    = r_oang;
    assign o_rsp.flywheel_rpm  = r_orpm;
    assign o_rsp.status        = r_ost;

    // ---------------- assertions ----------------
    a_tail_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail.vld |-> (r_state == S_SEARCH))
        else $error("query left the cell row outside the search phase");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_a == done_r)
        else $error("dividers out of step");

    a_query_starts_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_xfer && i_req.operation == OP_QUERY) |=> (r_state == S_SEARCH))
        else $error("accepted query did not start the row walk");

endmodule

/* tb/clit_lookup_checker.sv */
module clit_lookup_checker
    import clit_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    clit_req_if                  req_mon,
    clit_rsp_if                  rsp_mon,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    input  logic [PDATA_W-1:0]   prdata,
    output int                   o_fail_cnt,
    output int                   o_pending,
    output int                   o_n_interp,
    output int                   o_n_clamp,
    output int                   o_n_nomap,
    output int                   o_n_loads
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic [ANGLE_W-1:0] angle;
        logic [RPM_W-1:0]   rpm;
        logic [STAT_W-1:0]  status;
    } t_answer;

    t_point           cal_tab [MAX_POINTS];
    logic [CNT_W-1:0] points_used;
    t_answer          due_answers [$];
    int               fails, n_interp, n_clamp, n_nomap, n_loads;

    // truncating blend between two end values
    function automatic longint blend_val(longint off, longint span, longint a, longint b);
        if (span == 0)
            return a;
        return a + (off * (b - a)) / span;
    endfunction

    function automatic t_answer lookup_point(logic [RANGE_W-1:0] r);
        t_answer ans;
        int      n;
        longint  off, span;
        ans = '{range_mm: r, angle: '0, rpm: '0, status: ST_NOMAP};
        n = (points_used > MAX_POINTS) ? MAX_POINTS : int'(points_used);
        if (n == 0)
            return ans;
        if (n == 1 || r <= cal_tab[0].range_mm) begin
            ans.angle  = cal_tab[0].angle;
            ans.rpm    = cal_tab[0].rpm;
            ans.status = ST_CLAMP;
            return ans;
        end
        if (r >= cal_tab[n-1].range_mm) begin
            ans.angle  = cal_tab[n-1].angle;
            ans.rpm    = cal_tab[n-1].rpm;
            ans.status = ST_CLAMP;
            return ans;
        end
        for (int i = 0; i + 1 < n; i++) begin
            if (r >= cal_tab[i].range_mm && r <= cal_tab[i+1].range_mm) begin
                off  = longint'(r) - longint'(cal_tab[i].range_mm);
                span = longint'(cal_tab[i+1].range_mm) - longint'(cal_tab[i].range_mm);
                ans.angle  = ANGLE_W'(blend_val(off, span, cal_tab[i].angle,
                                                cal_tab[i+1].angle));
                ans.rpm    = RPM_W'(blend_val(off, span, cal_tab[i].rpm, cal_tab[i+1].rpm));
                ans.status = ST_INTERP;
                return ans;
            end
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer exp_a, got_a;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_POINTS; i++)
                cal_tab[i] = '0;
            cal_tab[0] = '{range_mm: 16'd1500, angle: 14'd2000, rpm: 15'd2500};
            cal_tab[1] = '{range_mm: 16'd2500, angle: 14'd2800, rpm: 15'd3200};
            cal_tab[2] = '{range_mm: 16'd3500, angle: 14'd3400, rpm: 15'd3900};
            cal_tab[3] = '{range_mm: 16'd4500, angle: 14'd3900, rpm: 15'd4500};
            points_used = COUNT_RESET;
            due_answers.delete();
        end else begin
            // register access phase
            if (psel && penable && paddr[2] == REG_POINT_COUNT) begin
                if (pwrite) begin
                    points_used = pwdata[CNT_W-1:0];
                end else if (prdata != PDATA_W'(points_used)) begin
                    fails++;
                    if (fails <= 10)
                        $display("%t point_count read: exp %0d got %0d",
                                 $realtime, points_used, prdata);
                end
            end
            // result transfer, checked against the oldest query
            if (rsp_mon.valid && rsp_mon.ready) begin
                got_a = '{rsp_mon.echo_range_mm, rsp_mon.hood_angle,
                          rsp_mon.flywheel_rpm, rsp_mon.status};
                if (due_answers.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%t unexpected result r=%0d ang=%0d rpm=%0d st=%0d",
                                 $realtime, got_a.range_mm, got_a.angle, got_a.rpm,
                                 got_a.status);
                end else begin
                    exp_a = due_answers.pop_front();
                    if (got_a !== exp_a) begin
                        fails++;
                        if (fails <= 10)
                            $display("%t mismatch exp r=%0d ang=%0d rpm=%0d st=%0d %s",
                                     $realtime, exp_a.range_mm, exp_a.angle, exp_a.rpm,
                                     exp_a.status,
                                     $sformatf("got r=%0d ang=%0d rpm=%0d st=%0d",
                                               got_a.range_mm, got_a.angle, got_a.rpm,
                                               got_a.status));
                    end
                    case (exp_a.status)
                        ST_INTERP: n_interp++;
                        ST_CLAMP:  n_clamp++;
                        default:   n_nomap++;
                    endcase
                end
            end
            // input transfer: load a point or predict a query
            if (req_mon.valid && req_mon.ready) begin
                if (req_mon.operation == OP_WRITE) begin
                    cal_tab[req_mon.entry_index] = '{req_mon.range_mm, req_mon.entry_angle,
                                                     req_mon.entry_rpm};
                    n_loads++;
                end else begin
                    due_answers.push_back(lookup_point(req_mon.range_mm));
                end
            end
        end
        o_fail_cnt <= fails;
        o_pending  <= due_answers.size();
        o_n_interp <= n_interp;
        o_n_clamp  <= n_clamp;
        o_n_nomap  <= n_nomap;
        o_n_loads  <= n_loads;
    end

    final begin
        if (due_answers.size() != 0)
            $display("%0d results never arrived", due_answers.size());
    end

endmodule

/* tb/clamped_linear_interpolation_table_unit_tb.sv */
module clamped_linear_interpolation_table_unit_tb;
    import clit_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_POINTS = 16;
    // leave margin after the last result
    localparam int SETTLE     = 80;
    localparam int LIMIT      = 1000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata, prdata;
    logic               pready;

    int fail_cnt, pending, n_interp, n_clamp, n_nomap, n_loads;
    int tx_idle_pct, rx_idle_pct, tx_burst, rx_burst;
    int cycles, n_counts;

    clit_req_if req_ch ();
    clit_rsp_if rsp_ch ();

    clamped_linear_interpolation_table_unit #(.MAX_POINTS(MAX_POINTS)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predicts every query and compares each result transfer
    clit_lookup_checker #(.MAX_POINTS(MAX_POINTS)) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .req_mon    (req_ch),
        .rsp_mon    (rsp_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending),
        .o_n_interp (n_interp),
        .o_n_clamp  (n_clamp),
        .o_n_nomap  (n_nomap),
        .o_n_loads  (n_loads)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stalls, with occasional stall-free stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (rx_burst > 0) begin
            rx_burst     <= rx_burst - 1;
            rsp_ch.ready <= 1'b1;
        end else if ($urandom_range(63) == 0) begin
            rx_burst     <= $urandom_range(40);
            rsp_ch.ready <= 1'b1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // one input transfer; valid stays high into the next call unless a gap comes
    task automatic send_item(logic op, logic [RANGE_W-1:0] r, logic [IDX_W-1:0] idx,
                             logic [ANGLE_W-1:0] ang, logic [RPM_W-1:0] rpm);
        if (tx_burst > 0) begin
            tx_burst--;
        end else if ($urandom_range(63) == 0) begin
            tx_burst = $urandom_range(40);
        end else if ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.range_mm    <= r;
        req_ch.entry_index <= idx;
        req_ch.entry_angle <= ang;
        req_ch.entry_rpm   <= rpm;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // a query; the unused load fields carry random values
    task automatic ask(logic [RANGE_W-1:0] r);
        send_item(OP_QUERY, r, IDX_W'($urandom), ANGLE_W'($urandom_range(9000)),
                  RPM_W'($urandom_range(20000)));
    endtask

    // drop valid and let the block drain before touching the register
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // write point_count, then read it back (checker compares the read data)
    task automatic set_count(logic [CNT_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= '0;
        pwdata  <= PDATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        n_counts++;
    endtask

    initial begin
        int          rng_tab [MAX_POINTS];
        int          pts, start, slot, new_cnt, nq, maxr, base, tmp, j, phase_items;
        bit          unordered;
        logic [15:0] loaded;
        logic [15:0] r;

        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.operation   <= OP_QUERY;
        req_ch.range_mm    <= '0;
        req_ch.entry_index <= '0;
        req_ch.entry_angle <= '0;
        req_ch.entry_rpm   <= '0;
        tx_idle_pct = 19;
        rx_idle_pct = 84;
        // starter points occupy slots 0..3 after reset
        loaded = 16'h000f;
        rng_tab[0] = 1500;
        rng_tab[1] = 2500;
        rng_tab[2] = 3500;
        rng_tab[3] = 4500;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: starter table, below/at/between/above the end points ---
        ask(16'd0);
        ask(16'd1500);
        ask(16'd2000);
        ask(16'd2999);
        ask(16'd4500);
        ask(16'hffff);
        // single point always clamps to it
        wait_idle();
        set_count(5'd1);
        ask(16'd30000);
        // empty table: no map, range still echoed
        wait_idle();
        set_count(5'd0);
        ask(16'd1234);
        ask(16'hffff);
        // fill the rest of the store in order, extreme angle and rpm values included
        for (int i = 4; i < MAX_POINTS; i++) begin
            tmp = (i == MAX_POINTS - 1) ? 65535 : 5000 * (i - 3);
            send_item(OP_WRITE, RANGE_W'(tmp), IDX_W'(i),
                      ANGLE_W'((i % 2) ? 9000 : 0), RPM_W'((i % 2) ? 0 : 20000));
            loaded[i] = 1'b1;
            rng_tab[i] = tmp;
        end
        // count above capacity acts as a full store
        wait_idle();
        set_count(5'd31);
        ask(16'd40001);
        ask(16'hffff);
        ask(16'd4999);

        // --- random: three handshake pressure phases ---
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 84 : 0;
            rx_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 19 : 0;
            tx_burst    = 0;
            phase_items = 0;
            while (phase_items < 600) begin
                // a fresh table of random size, mostly ascending
                pts = ($urandom_range(9) == 0) ? 0 :
                      ($urandom_range(3) == 0) ? MAX_POINTS : $urandom_range(1, MAX_POINTS);
                unordered = ($urandom_range(9) == 0);
                case ($urandom_range(2))
                    0:       maxr = 20;     // tight table, equal ranges likely
                    1:       maxr = 5000;
                    default: maxr = 65535;
                endcase
                base = $urandom_range(65535 - maxr);
                for (int i = 0; i < pts; i++)
                    rng_tab[i] = base + $urandom_range(maxr);
                if (!unordered) begin
                    for (int i = 1; i < pts; i++) begin
                        tmp = rng_tab[i];
                        j = i - 1;
                        while (j >= 0 && rng_tab[j] > tmp) begin
                            rng_tab[j+1] = rng_tab[j];
                            j--;
                        end
                        rng_tab[j+1] = tmp;
                    end
                end
                start = (pts > 0) ? $urandom_range(pts - 1) : 0;
                for (int i = 0; i < pts; i++) begin
                    slot = (start + i) % pts;
                    send_item(OP_WRITE, RANGE_W'(rng_tab[slot]), IDX_W'(slot),
                              ANGLE_W'($urandom_range(9000)), RPM_W'($urandom_range(20000)));
                    loaded[slot] = 1'b1;
                    phase_items++;
                end
                // stray load beyond the slots in use
                if (pts < MAX_POINTS && $urandom_range(3) == 0) begin
                    slot = $urandom_range(pts, MAX_POINTS - 1);
                    rng_tab[slot] = $urandom_range(65535);
                    send_item(OP_WRITE, RANGE_W'(rng_tab[slot]), IDX_W'(slot),
                              ANGLE_W'($urandom_range(9000)), RPM_W'($urandom_range(20000)));
                    loaded[slot] = 1'b1;
                    phase_items++;
                end
                wait_idle();
                new_cnt = pts;
                if (pts == MAX_POINTS && loaded == 16'hffff && $urandom_range(3) == 0)
                    new_cnt = $urandom_range(MAX_POINTS + 1, 31);
                set_count(CNT_W'(new_cnt));
                nq = $urandom_range(15, 40);
                for (int q = 0; q < nq; q++) begin
                    case ($urandom_range(9))
                        0:       r = 16'($urandom_range(65535));
                        1:       r = ($urandom_range(1) != 0) ? 16'hffff : 16'h0000;
                        2, 3:    r = (pts > 0) ? 16'(rng_tab[$urandom_range(pts - 1)]
                                                     + $urandom_range(2) - 1)
                                               : 16'($urandom_range(65535));
                        default: r = (pts > 0) ? 16'($urandom_range(rng_tab[0],
                                                                     rng_tab[pts - 1]))
                                               : 16'($urandom_range(65535));
                    endcase
                    ask(r);
                    phase_items++;
                end
                wait_idle();
            end
        end

        wait_idle();
        $display("covered %0d point loads, %0d count settings, queries: %0d interpolated,",
                 n_loads, n_counts, n_interp);
        $display("%0d clamped, %0d no map; mismatches %0d", n_clamp, n_nomap, fail_cnt);
        if (fail_cnt == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/clit_pkg.sv
src/clit_if.sv
src/clit_cell.sv
src/clit_div.sv
src/clamped_linear_interpolation_table_unit.sv
tb/clit_lookup_checker.sv
tb/clamped_linear_interpolation_table_unit_tb.sv
